/* design/itcf_pkg.sv */
// Shared types and constants for the IPv4 TTL/checksum forwarding unit.
package itcf_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 60;

    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;
    localparam int NIB_W  = 4;

    localparam logic [NIB_W-1:0] MIN_IHL          = 4'd5;
    localparam logic [LEN_W-1:0] MIN_HEADER_BYTES = 6'd20;

    localparam logic [LEN_W-1:0] TTL_IDX     = 6'd8;
    localparam logic [LEN_W-1:0] CSUM_HI_IDX = 6'd10;
    localparam logic [LEN_W-1:0] CSUM_LO_IDX = 6'd11;

    typedef struct packed {
        logic take;
        logic start_emit;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last_in;
        logic last_out;
    } t_dp_status;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

/* design/ipv4_ttl_checksum_forward_unit.sv */
// Top level of the IPv4 TTL decrement and header checksum rewrite unit.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_header_byte
//  output    out        o_out_valid / i_out_stall   o_checksum_ok, o_out_byte, o_last_byte
//
// An N-byte header is received byte by byte, checked in one check state, then
// emitted byte by byte from the single header buffer with one write and one read
// port. Input is stalled from the last header byte until the last output item
// is taken. Reset (synchronous, active low) returns the sequencer to receive and
// clears the byte counter; the buffer is not cleared.
module ipv4_ttl_checksum_forward_unit #(
    parameter int MAX_HEADER_BYTES = itcf_pkg::MAX_HEADER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [itcf_pkg::BYTE_W-1:0] i_header_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_checksum_ok,
    output logic [itcf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last_byte
);

    itcf_pkg::t_dp_cmd    cmd;
    itcf_pkg::t_dp_status status;

    itcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    itcf_datapath #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_header_byte (i_header_byte),
        .o_status      (status),
        .o_checksum_ok (o_checksum_ok),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

`ifndef SYNTHESIS
    // never take a new header byte while a header is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("input accepted during emit");

    // emit ends right after the last output item is taken
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_byte) |=> !o_out_valid)
        else $error("output valid after last item");

    // emit continues, with one ok flag, until the last item
    a_ok_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_byte) |=>
            (o_out_valid && o_checksum_ok == $past(o_checksum_ok)))
        else $error("emit broken or ok flag changed within header");
`endif

endmodule

/* design/itcf_ctrl.sv */
// Controller: receive, check and emit sequencing for one header at a time.
module itcf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  itcf_pkg::t_dp_status i_status,
    output itcf_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    localparam logic [1:0] S_RECV  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.take       = 1'b0;
        o_cmd.start_emit = 1'b0;
        o_cmd.advance    = 1'b0;
        o_in_stall       = 1'b1;
        o_out_valid      = 1'b0;
        unique case (r_state)
            S_RECV: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_status.last_in) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.start_emit = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = !i_out_stall;
                if (!i_out_stall && i_status.last_out) begin
                    n_state = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/itcf_datapath.sv */
// Datapath: header buffer, running sums, checksum check and output byte select.
module itcf_datapath #(
    parameter int MAX_HEADER_BYTES = itcf_pkg::MAX_HEADER_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  itcf_pkg::t_dp_cmd                 i_cmd,
    input  logic [itcf_pkg::BYTE_W-1:0]       i_header_byte,
    output itcf_pkg::t_dp_status              o_status,
    output logic                              o_checksum_ok,
    output logic [itcf_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_last_byte
);

    localparam int AW = $clog2(MAX_HEADER_BYTES);
    localparam logic [itcf_pkg::LEN_W-1:0] MAX_LEN = itcf_pkg::LEN_W'(MAX_HEADER_BYTES);

    logic [itcf_pkg::BYTE_W-1:0] r_mem [MAX_HEADER_BYTES];
    logic [itcf_pkg::BYTE_W-1:0] r_rd_data;

    logic [itcf_pkg::LEN_W-1:0]  r_count;
    logic [itcf_pkg::LEN_W-1:0]  r_len;
    logic [itcf_pkg::NIB_W-1:0]  r_nib;
    logic [itcf_pkg::SUM_W-1:0]  r_sum;
    logic [itcf_pkg::SUM_W-1:0]  r_sum_new;
    logic [itcf_pkg::BYTE_W-1:0] r_ttl_dec;
    logic [itcf_pkg::SUM_W-1:0]  r_csum_in;
    logic [itcf_pkg::SUM_W-1:0]  r_csum_out;
    logic                        r_ok;
    logic [itcf_pkg::LEN_W-1:0]  r_rd_addr;
    logic [itcf_pkg::LEN_W-1:0]  n_rd_addr;

    logic                        first;
    logic [itcf_pkg::NIB_W-1:0]  nib;
    logic [itcf_pkg::LEN_W-1:0]  nib_bytes;
    logic [itcf_pkg::LEN_W-1:0]  len_new;
    logic [itcf_pkg::LEN_W-1:0]  cur_len;
    logic [itcf_pkg::SUM_W-1:0]  weight;
    logic [itcf_pkg::SUM_W-1:0]  weight_new;
    logic [itcf_pkg::SUM_W-1:0]  sum_base;
    logic [itcf_pkg::SUM_W-1:0]  sum_new_base;
    logic [itcf_pkg::BYTE_W-1:0] byte_dec;
    logic                        bad;

    assign first     = (r_count == '0);
    assign nib       = i_header_byte[itcf_pkg::NIB_W-1:0];
    assign nib_bytes = {nib, 2'b00};

    always_comb begin
        if (nib < itcf_pkg::MIN_IHL) begin
            len_new = itcf_pkg::MIN_HEADER_BYTES;
        end else if (nib_bytes > MAX_LEN) begin
            len_new = MAX_LEN;
        end else begin
            len_new = nib_bytes;
        end
    end

    assign cur_len          = first ? len_new : r_len;
    assign o_status.last_in = ((r_count + 1'b1) == cur_len);
    assign byte_dec         = i_header_byte - 1'b1;

    // word weight of this byte; the second sum sees the TTL already decremented
    always_comb begin
        if (r_count == itcf_pkg::CSUM_HI_IDX || r_count == itcf_pkg::CSUM_LO_IDX) begin
            weight     = '0;
            weight_new = '0;
        end else if (r_count[0]) begin
            weight     = {8'h00, i_header_byte};
            weight_new = {8'h00, i_header_byte};
        end else if (r_count == itcf_pkg::TTL_IDX) begin
            weight     = {i_header_byte, 8'h00};
            weight_new = {byte_dec, 8'h00};
        end else begin
            weight     = {i_header_byte, 8'h00};
            weight_new = {i_header_byte, 8'h00};
        end
    end

    assign sum_base     = first ? '0 : r_sum;
    assign sum_new_base = first ? '0 : r_sum_new;

    assign bad = (r_nib < itcf_pkg::MIN_IHL) || ({r_nib, 2'b00} > MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_count <= o_status.last_in ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mem[r_count[AW-1:0]] <= i_header_byte;
            r_sum     <= itcf_pkg::ones_add(sum_base, weight);
            r_sum_new <= itcf_pkg::ones_add(sum_new_base, weight_new);
            if (first) begin
                r_len <= len_new;
                r_nib <= nib;
            end
            if (r_count == itcf_pkg::TTL_IDX) begin
                r_ttl_dec <= byte_dec;
            end
            if (r_count == itcf_pkg::CSUM_HI_IDX) begin
                r_csum_in[15:8] <= i_header_byte;
            end
            if (r_count == itcf_pkg::CSUM_LO_IDX) begin
                r_csum_in[7:0] <= i_header_byte;
            end
        end
        if (i_cmd.start_emit) begin
            r_ok       <= !bad && (r_csum_in == ~r_sum);
            r_csum_out <= ~r_sum_new;
        end
    end

    // read address tracks the byte on the output; data is read from the next address, so it matches
    always_comb begin
        if (i_cmd.start_emit) begin
            n_rd_addr = '0;
        end else if (i_cmd.advance) begin
            n_rd_addr = r_rd_addr + 1'b1;
        end else begin
            n_rd_addr = r_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
        end else begin
            r_rd_addr <= n_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[n_rd_addr[AW-1:0]];
    end

    assign o_status.last_out = ((r_rd_addr + 1'b1) == r_len);
    assign o_last_byte       = o_status.last_out;
    assign o_checksum_ok     = r_ok;

    always_comb begin
        if (r_ok && r_rd_addr == itcf_pkg::TTL_IDX) begin
            o_out_byte = r_ttl_dec;
        end else if (r_ok && r_rd_addr == itcf_pkg::CSUM_HI_IDX) begin
            o_out_byte = r_csum_out[15:8];
        end else if (r_ok && r_rd_addr == itcf_pkg::CSUM_LO_IDX) begin
            o_out_byte = r_csum_out[7:0];
        end else begin
            o_out_byte = r_rd_data;
        end
    end

endmodule

/* test/itcf_forward_checker.sv */
// Checker for the IPv4 TTL/checksum forwarding unit: predicts and compares output items.
module itcf_forward_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [itcf_pkg::BYTE_W-1:0] i_header_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_checksum_ok,
    input  logic [itcf_pkg::BYTE_W-1:0] i_out_byte,
    input  logic                        i_last_byte,
    output int                          o_mismatches,
    output int                          o_pending
);
    import itcf_pkg::*;

    localparam int HDR_DEPTH = MAX_HEADER_BYTES_DEF;

    typedef struct {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_fwd_byte;

    t_fwd_byte rewritten_q[$];

    logic [BYTE_W-1:0] hdr_buf [HDR_DEPTH];
    logic [LEN_W-1:0]  rx_count = '0;
    logic [LEN_W-1:0]  hdr_len  = '0;
    logic [SUM_W-1:0]  run_sum  = '0;

    int mismatch_cnt = 0;
    int pending_cnt  = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;

    // end-around carry folded once; two 16-bit terms never need a second fold
    function automatic logic [SUM_W-1:0] fold_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [31:0] wide;
        wide = 32'(a) + 32'(b);
        wide = (wide & 32'h0000_ffff) + (wide >> 16);
        return wide[SUM_W-1:0];
    endfunction

    // header word contribution of one byte; checksum field counts as zero
    function automatic logic [SUM_W-1:0] byte_term(input logic [LEN_W-1:0] idx,
                                                   input logic [BYTE_W-1:0] b);
        if (idx == CSUM_HI_IDX || idx == CSUM_LO_IDX)
            return '0;
        return idx[0] ? {8'h00, b} : {b, 8'h00};
    endfunction

    task automatic forward_header_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] csum;
        logic             good;
        t_fwd_byte        item;
        int               i;
        if (rx_count == '0) begin
            len = {b[3:0], 2'b00};
            if (len < MIN_HEADER_BYTES)
                len = MIN_HEADER_BYTES;
            hdr_len = len;
            run_sum = '0;
        end
        hdr_buf[rx_count] = b;
        run_sum  = fold_add(run_sum, byte_term(rx_count, b));
        rx_count = rx_count + 1'b1;
        if (rx_count < hdr_len)
            return;

        good = (hdr_buf[0][NIB_W-1:0] >= MIN_IHL) &&
               ({hdr_buf[CSUM_HI_IDX], hdr_buf[CSUM_LO_IDX]} == ~run_sum);
        if (good) begin
            hdr_buf[TTL_IDX] = hdr_buf[TTL_IDX] - 1'b1;
            csum = '0;
            for (i = 0; i < hdr_len; i++)
                csum = fold_add(csum, byte_term(LEN_W'(i), hdr_buf[i]));
            csum = ~csum;
            hdr_buf[CSUM_HI_IDX] = csum[15:8];
            hdr_buf[CSUM_LO_IDX] = csum[7:0];
        end
        for (i = 0; i < hdr_len; i++) begin
            item.ok   = good;
            item.data = hdr_buf[i];
            item.last = (i + 1 == hdr_len);
            rewritten_q.push_back(item);
        end
        rx_count = '0;
        hdr_len  = '0;
        run_sum  = '0;
    endtask

    always @(posedge i_clk) begin : monitor
        t_fwd_byte due;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (rewritten_q.size() == 0) begin
                    $error("unexpected output item: byte %0h ok %0b last %0b",
                           i_out_byte, i_checksum_ok, i_last_byte);
                    mismatch_cnt++;
                end else begin
                    due = rewritten_q.pop_front();
                    if (i_checksum_ok !== due.ok) begin
                        $error("checksum_ok mismatch: expected %0b, got %0b",
                               due.ok, i_checksum_ok);
                        mismatch_cnt++;
                    end
                    if (i_out_byte !== due.data) begin
                        $error("out_byte mismatch: expected %02h, got %02h",
                               due.data, i_out_byte);
                        mismatch_cnt++;
                    end
                    if (i_last_byte !== due.last) begin
                        $error("last_byte mismatch: expected %0b, got %0b",
                               due.last, i_last_byte);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                forward_header_byte(i_header_byte);
            pending_cnt = rewritten_q.size();
        end
    end

endmodule

/* test/tb_ipv4_ttl_checksum_forward_unit.sv */
// Testbench top for the IPv4 TTL/checksum forwarding unit: stimulus, clock and verdict.
module tb_ipv4_ttl_checksum_forward_unit;
    import itcf_pkg::*;

    localparam int HDR_DEPTH  = MAX_HEADER_BYTES_DEF;
    localparam int TX_TARGET  = 245;
    localparam int LONG_HOLD  = 200;
    localparam int DRAIN_WAIT = 2 * HDR_DEPTH + 20;

    typedef enum {
        HDR_EXTREME,
        HDR_GOOD,
        HDR_BAD_CSUM,
        HDR_SHORT_IHL,
        HDR_NOISE
    } t_hdr_kind;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] hdr_byte  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              csum_ok;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    int mismatches;
    int pending;
    int sent     = 0;
    bit tx_calm  = 1'b0;
    bit rx_calm  = 1'b0;

    ipv4_ttl_checksum_forward_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_header_byte (hdr_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_checksum_ok (csum_ok),
        .o_out_byte    (out_byte),
        .o_last_byte   (last_byte)
    );

    itcf_forward_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_header_byte (hdr_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_checksum_ok (csum_ok),
        .i_out_byte    (out_byte),
        .i_last_byte   (last_byte),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ones-complement header sum used to build headers with a valid checksum
    function automatic logic [SUM_W-1:0] header_sum(input logic [BYTE_W-1:0] h [HDR_DEPTH],
                                                    input int len);
        logic [31:0] acc;
        int          i;
        acc = '0;
        for (i = 0; i < len; i++) begin
            if (i != CSUM_HI_IDX && i != CSUM_LO_IDX)
                acc += (i % 2) ? 32'(h[i]) : (32'(h[i]) << 8);
        end
        acc = (acc & 32'hffff) + (acc >> 16);
        acc = (acc & 32'hffff) + (acc >> 16);
        return acc[SUM_W-1:0];
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        hdr_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_header(input t_hdr_kind kind, input bit force_max);
        logic [BYTE_W-1:0] hdr [HDR_DEPTH];
        logic [NIB_W-1:0]  ihl;
        logic [SUM_W-1:0]  cs;
        int                len;
        int                idx;
        int                i;
        for (i = 0; i < HDR_DEPTH; i++)
            hdr[i] = $urandom_range(0, 255);
        case (kind)
            HDR_EXTREME: begin
                for (i = 0; i < HDR_DEPTH; i++)
                    hdr[i] = (i % 2) ? 8'hff : 8'h00;
                ihl = MIN_IHL;
            end
            HDR_SHORT_IHL: ihl = $urandom_range(0, 4);
            HDR_NOISE:     ihl = hdr[0][3:0];
            default: begin
                if (force_max || $urandom_range(0, 7) == 0)
                    ihl = 4'hf;
                else
                    ihl = $urandom_range(5, 8);
            end
        endcase
        len = (ihl < MIN_IHL) ? MIN_HEADER_BYTES : ihl * 4;

        if (kind != HDR_NOISE) begin
            hdr[0] = {(kind != HDR_EXTREME && $urandom_range(0, 3) == 0) ?
                      hdr[0][7:4] : 4'h4, ihl};
            if (kind == HDR_EXTREME)
                hdr[TTL_IDX] = 8'h00;
            else begin
                case ($urandom_range(0, 5))
                    0: hdr[TTL_IDX] = 8'h00;
                    1: hdr[TTL_IDX] = 8'h01;
                    2: hdr[TTL_IDX] = 8'hff;
                    default: ;
                endcase
            end
            cs = ~header_sum(hdr, len);
            hdr[CSUM_HI_IDX] = cs[15:8];
            hdr[CSUM_LO_IDX] = cs[7:0];
            if (kind == HDR_BAD_CSUM) begin
                idx = $urandom_range(0, 1) ? CSUM_HI_IDX : CSUM_LO_IDX;
                hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
            end
        end

        tx_calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++)
            send_byte(hdr[i]);
    endtask

    // output side: random stalls per item, plus long hold-offs to back up the input
    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (taken == 30 || taken == 250)
                gap = LONG_HOLD;
            else if (rx_calm)
                gap = 0;
            else
                gap = $urandom_range(0, 12);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            if (taken % 40 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            @(negedge clk);
        end
    end

    initial begin
        int r;
        t_hdr_kind kind;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // valid header with TTL zero and alternating all-ones/all-zeros content
        send_header(HDR_EXTREME, 1'b0);

        // first random headers walk through each case once
        send_header(HDR_SHORT_IHL, 1'b0);
        send_header(HDR_BAD_CSUM, 1'b0);
        send_header(HDR_GOOD, 1'b1);
        send_header(HDR_NOISE, 1'b0);
        while (sent < TX_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                kind = HDR_GOOD;
            else if (r < 8)
                kind = HDR_BAD_CSUM;
            else if (r == 8)
                kind = HDR_SHORT_IHL;
            else
                kind = HDR_NOISE;
            send_header(kind, 1'b0);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
